[src/yuyv_to_rgb_pixel_stream_core_macros.svh]
// Assertion macros shared by the YUYV to RGB checker.
`ifndef YUYV_TO_RGB_PIXEL_STREAM_CORE_MACROS_SVH
`define YUYV_TO_RGB_PIXEL_STREAM_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define YRC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define YRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/yrc_pkg.sv]
// Shared constants, types and the channel scaling function of the YUYV to RGB core.
package yrc_pkg;

    localparam int COORD_BITS_DEF   = 12;
    localparam int LINE_WIDTH_RST   = 640;
    localparam int FRAME_HEIGHT_RST = 480;

    // APB register map
    localparam int   APB_ADDR_BITS    = 3;
    localparam logic REG_LINE_WIDTH   = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam int IN_TDATA_W = 32;
    localparam int LUMA_W     = 8;
    localparam int CHROMA_W   = 9;    // chroma minus bias, signed
    localparam int CHROMA_BIAS = 128;
    localparam int FRAC_BITS  = 16;   // Q16 coefficients
    localparam int PROD_W     = 25;
    localparam int SUM_W      = 27;
    localparam int LEVEL_W    = 8;
    localparam int LEVEL_MAX  = 255;
    localparam int LEVEL_TOP  = 219;  // 255 * 220 / 256, floored
    localparam int LEVEL_GAIN = 220;
    localparam int SCALE_SHIFT = 8;

    localparam logic signed [PROD_W-1:0] K_RV = 89830;
    localparam logic signed [PROD_W-1:0] K_GV = 45744;
    localparam logic signed [PROD_W-1:0] K_GU = 22127;
    localparam logic signed [PROD_W-1:0] K_BU = 113538;

    // chroma products, common to both pixels of a word
    typedef struct packed {
        logic signed [PROD_W-1:0] rv;
        logic signed [PROD_W-1:0] gv;
        logic signed [PROD_W-1:0] gu;
        logic signed [PROD_W-1:0] bu;
    } chroma_prod_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic frame_done;
        logic last_of_pair;
    } pix_flags_t;

    // negative -> 0, integer part clamped to 255, then * 220 / 256 floored
    function automatic logic [LEVEL_W-1:0] scale_level(input logic signed [SUM_W-1:0] s);
        logic [SUM_W-FRAC_BITS-2:0] c_wide;
        logic [LEVEL_W-1:0]         c;
        logic [2*LEVEL_W-1:0]       p;
        c_wide = s[SUM_W-2:FRAC_BITS];
        if (c_wide > (SUM_W-FRAC_BITS-1)'(LEVEL_MAX))
            c = LEVEL_W'(LEVEL_MAX);
        else
            c = c_wide[LEVEL_W-1:0];
        p = (2*LEVEL_W)'(c) * (2*LEVEL_W)'(LEVEL_GAIN);
        if (s[SUM_W-1])
            return '0;
        return p[SCALE_SHIFT +: LEVEL_W];
    endfunction

endpackage

[src/yrc_coord.sv]
// Frame row and column counters; tags both pixels of an accepted word.
module yrc_coord
    import yrc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  logic [COORD_BITS-1:0] line_width,
    input  logic [COORD_BITS-1:0] frame_height,
    output logic [COORD_BITS-1:0] row0,
    output logic [COORD_BITS-1:0] col0,
    output logic [COORD_BITS-1:0] row1,
    output logic [COORD_BITS-1:0] col1,
    output pix_flags_t            flags0,
    output pix_flags_t            flags1
);

    logic [COORD_BITS-1:0] row_reg, row_next;
    logic [COORD_BITS-1:0] col_reg, col_next;
    logic                  eol0, eof0, eol1, eof1;

    // pixel 0 sits at the current counters
    assign row0 = row_reg;
    assign col0 = col_reg;
    assign eol0 = ({1'b0, col_reg} + 1'b1) >= {1'b0, line_width};
    assign eof0 = eol0 && (({1'b0, row_reg} + 1'b1) >= {1'b0, frame_height});

    // pixel 1 after one advance
    assign row1 = eol0 ? (eof0 ? '0 : row_reg + 1'b1) : row_reg;
    assign col1 = eol0 ? '0 : col_reg + 1'b1;
    assign eol1 = ({1'b0, col1} + 1'b1) >= {1'b0, line_width};
    assign eof1 = eol1 && (({1'b0, row1} + 1'b1) >= {1'b0, frame_height});

    assign row_next = eol1 ? (eof1 ? '0 : row1 + 1'b1) : row1;
    assign col_next = eol1 ? '0 : col1 + 1'b1;

    assign flags0.last_of_pair = 1'b0;
    assign flags0.frame_done   = eof0;
    assign flags1.last_of_pair = 1'b1;
    assign flags1.frame_done   = eof1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (advance)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

endmodule

[src/yrc_lane.sv]
// One colour lane: luma plus chroma products, clamp and 220/256 scale.
module yrc_lane
    import yrc_pkg::*;
(
    input  logic [LUMA_W-1:0] luma,
    input  chroma_prod_t      prod,
    output rgb_t              rgb
);

    logic signed [SUM_W-1:0] y16;
    logic signed [SUM_W-1:0] sum_r;
    logic signed [SUM_W-1:0] sum_g;
    logic signed [SUM_W-1:0] sum_b;

    assign y16   = $signed(SUM_W'({luma, FRAC_BITS'(0)}));
    assign sum_r = y16 + SUM_W'(prod.rv);
    assign sum_g = y16 - SUM_W'(prod.gv) - SUM_W'(prod.gu);
    assign sum_b = y16 + SUM_W'(prod.bu);

    assign rgb.red   = scale_level(sum_r);
    assign rgb.green = scale_level(sum_g);
    assign rgb.blue  = scale_level(sum_b);

endmodule

[src/yrc_merge.sv]
// Pair register: holds both lane results and sends them as two output beats.
module yrc_merge
    import yrc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int TDATA_W    = ((2*COORD_BITS + 3*LEVEL_W + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load_vld,
    output logic                  load_rdy,
    input  logic [COORD_BITS-1:0] row0,
    input  logic [COORD_BITS-1:0] col0,
    input  rgb_t                  rgb0,
    input  pix_flags_t            flags0,
    input  logic [COORD_BITS-1:0] row1,
    input  logic [COORD_BITS-1:0] col1,
    input  rgb_t                  rgb1,
    input  pix_flags_t            flags1,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata,
    output logic                  m_tlast,
    output logic                  m_tuser
);

    logic                  pair_vld_reg, pair_vld_next;
    logic                  half_reg, half_next;
    logic [COORD_BITS-1:0] row_reg   [2];
    logic [COORD_BITS-1:0] col_reg   [2];
    rgb_t                  rgb_reg   [2];
    pix_flags_t            flags_reg [2];
    logic                  beat;

    assign beat     = pair_vld_reg && m_tready;
    assign load_rdy = !pair_vld_reg || (m_tready && half_reg);

    always_comb
    begin
        pair_vld_next = pair_vld_reg;
        half_next     = half_reg;
        if (load_rdy)
        begin
            pair_vld_next = load_vld;
            half_next     = 1'b0;
        end
        else if (beat)
        begin
            half_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_vld_reg <= 1'b0;
            half_reg     <= 1'b0;
        end
        else
        begin
            pair_vld_reg <= pair_vld_next;
            half_reg     <= half_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_rdy && load_vld)
        begin
            row_reg[0]   <= row0;
            col_reg[0]   <= col0;
            rgb_reg[0]   <= rgb0;
            flags_reg[0] <= flags0;
            row_reg[1]   <= row1;
            col_reg[1]   <= col1;
            rgb_reg[1]   <= rgb1;
            flags_reg[1] <= flags1;
        end
    end

    assign m_tvalid = pair_vld_reg;
    assign m_tdata  = TDATA_W'({rgb_reg[half_reg].blue, rgb_reg[half_reg].green,
                                rgb_reg[half_reg].red, col_reg[half_reg], row_reg[half_reg]});
    assign m_tlast  = flags_reg[half_reg].frame_done;
    assign m_tuser  = flags_reg[half_reg].last_of_pair;

endmodule

[src/yuyv_to_rgb_pixel_stream_core.sv]
// Top level of the YUYV 4:2:2 to RGB pixel stream converter.
//
// Input channel (s_*): one YUYV word per beat, Y0 in bits 7:0, U 15:8, Y1 23:16,
// V 31:24. Output channel (m_*): one pixel per beat, Y0 pixel first, then Y1.
// Each pixel carries its row and column in the frame, RGB levels in 0..219,
// m_tuser high on the second pixel of a word and m_tlast on the last pixel of
// the frame. line_width and frame_height are set over APB at 0x0 and 0x4 while
// the stream is idle.
//
// Path: a word taken on s_* is registered in the product stage, then passes
// through the colour lanes into the pair register, which drives m_*.
// Throughput: two output beats per word, so the output port, one pixel per beat,
// sets the sustained word rate. Both colour lanes run in the same cycle, so the
// conversion itself keeps up with a word per cycle. Reset clears the frame
// counters to row 0, column 0, loads 640 x 480 and empties the pipeline. When
// the receiver stalls, the current pixel holds on m_tdata; the product stage
// keeps taking words until it and the pair register are both full, then
// s_tready drops.
module yuyv_to_rgb_pixel_stream_core
    import yrc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int TDATA_W    = ((2*COORD_BITS + 3*LEVEL_W + 7) / 8) * 8
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // APB configuration
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    // YUYV in
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [IN_TDATA_W-1:0]    s_tdata,   // yuyv_word
    // pixels out
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [TDATA_W-1:0]       m_tdata,   // pixel_row, pixel_column, red, green, blue
    output logic                     m_tlast,   // frame_done
    output logic                     m_tuser    // last_of_pair
);

    // ---------------- configuration registers ----------------
    logic [COORD_BITS-1:0] line_width_reg;
    logic [COORD_BITS-1:0] frame_height_reg;
    logic                  cfg_wr;
    logic                  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[APB_ADDR_BITS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg   <= COORD_BITS'(LINE_WIDTH_RST);
            frame_height_reg <= COORD_BITS'(FRAME_HEIGHT_RST);
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_LINE_WIDTH:   line_width_reg   <= pwdata[COORD_BITS-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[COORD_BITS-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_LINE_WIDTH:   prdata = 32'(line_width_reg);
            REG_FRAME_HEIGHT: prdata = 32'(frame_height_reg);
            default:          prdata = '0;
        endcase
    end

    // ---------------- input beat, coordinates, chroma products ----------------
    logic                       in_beat;
    logic                       merge_rdy;
    logic                       s1_vld_reg, s1_vld_next;
    logic [LUMA_W-1:0]          s1_y0_reg, s1_y1_reg;
    chroma_prod_t               s1_prod_reg, s1_prod_next;
    logic [COORD_BITS-1:0]      s1_row0_reg, s1_col0_reg, s1_row1_reg, s1_col1_reg;
    pix_flags_t                 s1_flags0_reg, s1_flags1_reg;
    logic signed [CHROMA_W-1:0] du, dv;
    logic [COORD_BITS-1:0]      row0, col0, row1, col1;
    pix_flags_t                 flags0, flags1;

    // product stage frees up whenever the pair register takes its word
    assign s_tready = !s1_vld_reg || merge_rdy;
    assign in_beat  = s_tvalid && s_tready;

    yrc_coord #(
        .COORD_BITS (COORD_BITS)
    ) u_coord (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (in_beat),
        .line_width   (line_width_reg),
        .frame_height (frame_height_reg),
        .row0         (row0),
        .col0         (col0),
        .row1         (row1),
        .col1         (col1),
        .flags0       (flags0),
        .flags1       (flags1)
    );

    // chroma is shared by the pair, so four products per word
    assign du = $signed({1'b0, s_tdata[15:8]})  - $signed(CHROMA_W'(CHROMA_BIAS));
    assign dv = $signed({1'b0, s_tdata[31:24]}) - $signed(CHROMA_W'(CHROMA_BIAS));

    always_comb
    begin
        s1_prod_next.rv = K_RV * PROD_W'(dv);
        s1_prod_next.gv = K_GV * PROD_W'(dv);
        s1_prod_next.gu = K_GU * PROD_W'(du);
        s1_prod_next.bu = K_BU * PROD_W'(du);
    end

    assign s1_vld_next = s_tready ? s_tvalid : s1_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else
            s1_vld_reg <= s1_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            s1_y0_reg     <= s_tdata[7:0];
            s1_y1_reg     <= s_tdata[23:16];
            s1_prod_reg   <= s1_prod_next;
            s1_row0_reg   <= row0;
            s1_col0_reg   <= col0;
            s1_row1_reg   <= row1;
            s1_col1_reg   <= col1;
            s1_flags0_reg <= flags0;
            s1_flags1_reg <= flags1;
        end
    end

    // ---------------- two colour lanes ----------------
    rgb_t rgb0, rgb1;

    yrc_lane u_lane0 (
        .luma (s1_y0_reg),
        .prod (s1_prod_reg),
        .rgb  (rgb0)
    );

    yrc_lane u_lane1 (
        .luma (s1_y1_reg),
        .prod (s1_prod_reg),
        .rgb  (rgb1)
    );

    // ---------------- merge into the pixel stream ----------------
    yrc_merge #(
        .COORD_BITS (COORD_BITS),
        .TDATA_W    (TDATA_W)
    ) u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .load_vld (s1_vld_reg),
        .load_rdy (merge_rdy),
        .row0     (s1_row0_reg),
        .col0     (s1_col0_reg),
        .rgb0     (rgb0),
        .flags0   (s1_flags0_reg),
        .row1     (s1_row1_reg),
        .col1     (s1_col1_reg),
        .rgb1     (rgb1),
        .flags1   (s1_flags1_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

[src/yrc_checker.sv]
// Port-level checker for the YUYV to RGB core, bound to the top level.
`include "yuyv_to_rgb_pixel_stream_core_macros.svh"

module yrc_checker
    import yrc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int TDATA_W    = ((2*COORD_BITS + 3*LEVEL_W + 7) / 8) * 8
)
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     m_tvalid,
    input logic                     m_tready,
    input logic [TDATA_W-1:0]       m_tdata,
    input logic                     m_tlast,
    input logic                     m_tuser
);

    localparam int RED_LSB   = 2*COORD_BITS;
    localparam int GREEN_LSB = RED_LSB + LEVEL_W;
    localparam int BLUE_LSB  = GREEN_LSB + LEVEL_W;

    logic out_beat;
    logic [COORD_BITS-1:0] out_row, out_col;

    assign out_beat = m_tvalid && m_tready;
    assign out_row  = m_tdata[COORD_BITS-1:0];
    assign out_col  = m_tdata[2*COORD_BITS-1:COORD_BITS];

    // stalled pixel beat holds
    `YRC_ASSERT_NEXT(a_hold_on_stall, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser),
        "output beat changed while stalled")

    // second pixel of a word is ready straight after the first
    `YRC_ASSERT_NEXT(a_pair_follows, out_beat && !m_tuser, m_tvalid && m_tuser,
        "second pixel of word not presented after first")

    // scaled levels never exceed 219
    `YRC_ASSERT_SAME(a_level_range, m_tvalid,
        (m_tdata[RED_LSB +: LEVEL_W] <= LEVEL_W'(LEVEL_TOP)) &&
        (m_tdata[GREEN_LSB +: LEVEL_W] <= LEVEL_W'(LEVEL_TOP)) &&
        (m_tdata[BLUE_LSB +: LEVEL_W] <= LEVEL_W'(LEVEL_TOP)),
        "colour level above 219")

    // frame end is followed by the pixel at row 0, column 0
    `YRC_ASSERT_NEXT(a_frame_wrap, out_beat && m_tlast,
        !m_tvalid || ((out_row == '0) && (out_col == '0)),
        "pixel after frame end not at origin")

endmodule

bind yuyv_to_rgb_pixel_stream_core yrc_checker #(
    .COORD_BITS (COORD_BITS),
    .TDATA_W    (TDATA_W)
) u_yrc_checker (.*);
